// ===== hw/rtl/xlz_pkg.sv =====
package xlz_pkg;

	localparam int unsigned HistDepth   = 8192;
	localparam int unsigned HistAw      = $clog2(HistDepth);
	localparam int unsigned MaxBlock    = 65535;
	localparam int unsigned HeaderBytes = 8;

	typedef enum logic [3:0] {
		PH_HDR    = 4'd0,
		PH_STORED = 4'd1,
		PH_SKIP   = 4'd2,
		PH_FLAGS  = 4'd3,
		PH_ITEM   = 4'd4,
		PH_TOKEN  = 4'd5,
		PH_NIB    = 4'd6,
		PH_EXT8   = 4'd7,
		PH_EXT16  = 4'd8,
		PH_EXT32  = 4'd9,
		PH_COPY   = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_SIZE    = 3'd1,
		ERR_OFFSET  = 3'd2,
		ERR_EXTLEN  = 3'd3,
		ERR_OVERRUN = 3'd4,
		ERR_SHORT   = 3'd5,
		ERR_TRUNC   = 3'd6
	} err_t;

	typedef struct packed {
		logic       byte_present;
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic       byte_taken;
		logic       out_valid;
		logic [7:0] out_byte;
		logic       block_last;
		logic [2:0] error_code;
	} out_word_t;

	// per-item result of the control logic
	typedef struct packed {
		logic              taken;
		logic              emit;
		logic              copy;
		logic [7:0]        lit;
		logic              last;
		logic [2:0]        err;
		logic [HistAw-1:0] raddr;
		logic [HistAw-1:0] waddr;
	} res_t;

endpackage

// ===== hw/rtl/xpress_lz77_frame_decompressor.sv =====
// Plain-LZ77 frame decompressor. One input word is taken per clock and gives
// exactly one output word in the next cycle; the input is stalled only while the
// output register holds a word that is itself stalled. During a match copy each
// word emits one history byte and leaves the offered compressed byte untaken,
// so a match of length n costs n words. The 8 KiB history is a single-port-write,
// single-port-read RAM with registered read data; a read of the byte written
// by the previous word is forwarded around the RAM. No clearing pass is needed.
module xpress_lz77_frame_decompressor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  xlz_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output xlz_pkg::out_word_t out_word,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data
);
	import xlz_pkg::*;

	logic              in_accept;
	res_t              res;
	res_t              s2_q;
	logic              ov_q;
	logic              wr_pend_q;
	logic              fwd_q;
	logic [7:0]        fwd_byte_q;
	logic [7:0]        rdata;
	logic [7:0]        s2_byte;

	assign in_stall  = ov_q & out_stall;
	assign in_accept = in_valid & ~in_stall;

	xlz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_accept),
		.in_word  (in_word),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.res      (res)
	);

	xlz_hist u_hist (
		.clk   (clk),
		.we    (wr_pend_q),
		.waddr (s2_q.waddr),
		.wdata (s2_byte),
		.re    (in_accept),
		.raddr (res.raddr),
		.rdata (rdata)
	);

	assign s2_byte = s2_q.copy ? (fwd_q ? fwd_byte_q : rdata) : s2_q.lit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q      <= 1'b0;
			wr_pend_q <= 1'b0;
		end else begin
			wr_pend_q <= in_accept & res.emit;
			if (in_accept) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			s2_q       <= res;
			fwd_q      <= wr_pend_q && (res.raddr == s2_q.waddr);
			fwd_byte_q <= s2_byte;
		end
	end

	assign out_valid           = ov_q;
	assign out_word.byte_taken = s2_q.taken;
	assign out_word.out_valid  = s2_q.emit;
	assign out_word.out_byte   = s2_q.emit ? s2_byte : 8'd0;
	assign out_word.block_last = s2_q.last;
	assign out_word.error_code = s2_q.err;

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && ov_q && s2_q.err != ERR_NONE) |=> (s2_q.err == $past(s2_q.err)))
		else $error("error code changed after being raised");

	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && ov_q && s2_q.err != ERR_NONE) |=> (!s2_q.taken && !s2_q.emit))
		else $error("activity after sticky error");

	a_copy_word: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && s2_q.copy) |-> (!s2_q.taken && s2_q.emit))
		else $error("copy word took input or emitted nothing");

	a_write_follows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_q |-> $past(in_accept))
		else $error("history write without accepted word");

endmodule

// ===== hw/rtl/xlz_hist.sv =====
module xlz_hist (
	input  logic                      clk,
	input  logic                      we,
	input  logic [xlz_pkg::HistAw-1:0] waddr,
	input  logic [7:0]                wdata,
	input  logic                      re,
	input  logic [xlz_pkg::HistAw-1:0] raddr,
	output logic [7:0]                rdata
);
	import xlz_pkg::*;

	logic [7:0] mem [HistDepth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/xlz_ctrl.sv =====
module xlz_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  xlz_pkg::in_word_t in_word,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	output xlz_pkg::res_t     res
);
	import xlz_pkg::*;

	phase_t            phase_q, n_phase;
	logic [63:0]       hdr_q, n_hdr;
	logic [15:0]       comp_left_q, n_comp;
	logic [15:0]       out_left_q, n_oleft;
	logic [15:0]       out_cnt_q, n_cnt;
	logic [31:0]       flag_q, n_flag;
	logic [5:0]        flag_left_q, n_flag_left;
	logic [31:0]       asm_q, n_asm;
	logic [2:0]        fbl_q, n_fbl;
	logic [3:0]        nib_q, n_nib;
	logic              nib_v_q, n_nib_v;
	logic [15:0]       copy_left_q, n_copy_left;
	logic [13:0]       dist_q, n_dist;
	logic [HistAw-1:0] wp_q, n_wp;
	logic [2:0]        err_q, n_err;
	logic [15:0]       limit_q;

	logic [15:0] lim;
	logic [7:0]  b;
	logic        emit_now, sm_req, res_req, after_req;
	logic [32:0] sm_len;
	logic [3:0]  res_n;
	logic [15:0] v16;
	logic [31:0] orig, comp;

	assign lim = (limit_q < 16'(MaxBlock)) ? limit_q : 16'(MaxBlock);
	assign b   = in_word.data_byte;

	always_comb begin
		n_phase     = phase_q;
		n_hdr       = hdr_q;
		n_comp      = comp_left_q;
		n_oleft     = out_left_q;
		n_cnt       = out_cnt_q;
		n_flag      = flag_q;
		n_flag_left = flag_left_q;
		n_asm       = asm_q;
		n_fbl       = fbl_q;
		n_nib       = nib_q;
		n_nib_v     = nib_v_q;
		n_copy_left = copy_left_q;
		n_dist      = dist_q;
		n_wp        = wp_q;
		n_err       = err_q;
		emit_now    = 1'b0;
		sm_req      = 1'b0;
		sm_len      = '0;
		res_req     = 1'b0;
		res_n       = '0;
		after_req   = 1'b0;
		v16         = '0;
		orig        = hdr_q[31:0];
		comp        = hdr_q[63:32];
		res         = '0;
		res.waddr   = wp_q;
		res.raddr   = wp_q - dist_q[HistAw-1:0];

		if (err_q == ERR_NONE) begin
			if (phase_q == PH_COPY) begin
				n_copy_left = copy_left_q - 16'd1;
				emit_now    = 1'b1;
				res.copy    = 1'b1;
				if (out_left_q != 16'd1 && n_copy_left == 16'd0) begin
					after_req = 1'b1;
				end
			end else if (phase_q >= PH_FLAGS && comp_left_q == 16'd0) begin
				n_err = ERR_SHORT;
			end else if (in_word.byte_present) begin
				res.taken = 1'b1;
				if (phase_q == PH_HDR) begin
					n_hdr = {b, hdr_q[63:8]};
					if (fbl_q >= 3'(HeaderBytes - 1)) begin
						n_fbl = '0;
						orig  = n_hdr[31:0];
						comp  = n_hdr[63:32];
						if (orig > {16'd0, lim} || comp > {16'd0, lim}) begin
							n_err = ERR_SIZE;
						end else begin
							n_comp      = comp[15:0];
							n_oleft     = orig[15:0];
							n_cnt       = '0;
							n_nib_v     = 1'b0;
							n_flag_left = '0;
							if (orig == 32'd0) begin
								n_phase = (comp != 32'd0) ? PH_SKIP : PH_HDR;
							end else if (orig == comp) begin
								n_phase = PH_STORED;
							end else begin
								n_phase = PH_FLAGS;
							end
						end
					end else begin
						n_fbl = fbl_q + 3'd1;
					end
				end else begin
					n_comp = comp_left_q - 16'd1;
					case (phase_q)
						PH_STORED: begin
							emit_now = 1'b1;
							res.lit  = b;
						end
						PH_SKIP: begin
							if (n_comp == 16'd0) begin
								n_phase = PH_HDR;
							end
						end
						PH_FLAGS: begin
							n_asm = {b, asm_q[31:8]};
							n_fbl = fbl_q + 3'd1;
							if (fbl_q == 3'd3) begin
								n_flag      = n_asm;
								n_flag_left = 6'd32;
								n_fbl       = '0;
								n_phase     = PH_ITEM;
							end
						end
						PH_ITEM: begin
							n_flag      = {flag_q[30:0], 1'b0};
							n_flag_left = flag_left_q - 6'd1;
							if (!flag_q[31]) begin
								emit_now = 1'b1;
								res.lit  = b;
								if (out_left_q != 16'd1) begin
									after_req = 1'b1;
								end
							end else begin
								n_asm   = {24'd0, b};
								n_phase = PH_TOKEN;
							end
						end
						PH_TOKEN: begin
							v16    = {b, asm_q[7:0]};
							n_dist = {1'b0, v16[15:3]} + 14'd1;
							n_asm  = '0;
							n_fbl  = '0;
							if (v16[2:0] != 3'h7) begin
								sm_req = 1'b1;
								sm_len = 33'(v16[2:0]) + 33'd3;
							end else if (nib_v_q) begin
								n_nib_v = 1'b0;
								res_req = 1'b1;
								res_n   = nib_q;
							end else begin
								n_phase = PH_NIB;
							end
						end
						PH_NIB: begin
							n_nib   = b[7:4];
							n_nib_v = 1'b1;
							res_req = 1'b1;
							res_n   = b[3:0];
						end
						PH_EXT8: begin
							if (b != 8'd255) begin
								sm_req = 1'b1;
								sm_len = 33'(b) + 33'd25;
							end else begin
								n_asm   = '0;
								n_fbl   = '0;
								n_phase = PH_EXT16;
							end
						end
						PH_EXT16: begin
							n_asm = {b, asm_q[31:8]};
							n_fbl = fbl_q + 3'd1;
							if (fbl_q == 3'd1) begin
								v16   = n_asm[31:16];
								n_asm = '0;
								n_fbl = '0;
								if (v16 == 16'd0) begin
									n_phase = PH_EXT32;
								end else if (v16 < 16'd22) begin
									n_err = ERR_EXTLEN;
								end else begin
									sm_req = 1'b1;
									sm_len = 33'(v16) + 33'd3;
								end
							end
						end
						PH_EXT32: begin
							n_asm = {b, asm_q[31:8]};
							n_fbl = fbl_q + 3'd1;
							if (fbl_q == 3'd3) begin
								n_fbl = '0;
								if (n_asm < 32'd22) begin
									n_err = ERR_EXTLEN;
								end else begin
									sm_req = 1'b1;
									sm_len = 33'(n_asm) + 33'd3;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end

			if (res_req) begin
				if (res_n != 4'hF) begin
					sm_req = 1'b1;
					sm_len = 33'(res_n) + 33'd10;
				end else begin
					n_phase = PH_EXT8;
				end
			end

			if (sm_req) begin
				if (n_dist > {1'b0, out_cnt_q[15:0]} && n_dist[13] == 1'b0
						|| n_dist > 14'({1'b0, out_cnt_q[12:0]}) && out_cnt_q[15:13] == 3'd0) begin
					n_err = ERR_OFFSET;
				end else if (sm_len > 33'(out_left_q)) begin
					n_err = ERR_OVERRUN;
				end else begin
					n_copy_left = sm_len[15:0];
					n_phase     = PH_COPY;
				end
			end

			if (after_req) begin
				n_fbl   = '0;
				n_phase = (n_flag_left != 6'd0) ? PH_ITEM : PH_FLAGS;
			end

			if (emit_now) begin
				res.emit = 1'b1;
				n_wp     = wp_q + HistAw'(1);
				n_cnt    = out_cnt_q + 16'd1;
				n_oleft  = out_left_q - 16'd1;
				if (out_left_q == 16'd1) begin
					res.last = 1'b1;
					n_fbl    = '0;
					n_phase  = (n_comp != 16'd0) ? PH_SKIP : PH_HDR;
				end
			end

			if (n_err == ERR_NONE && in_word.end_of_stream && n_phase != PH_COPY
					&& !(n_phase == PH_HDR && n_fbl == 3'd0)) begin
				n_err = ERR_TRUNC;
			end
		end
		res.err = n_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR;
			hdr_q       <= '0;
			comp_left_q <= '0;
			out_left_q  <= '0;
			out_cnt_q   <= '0;
			flag_q      <= '0;
			flag_left_q <= '0;
			asm_q       <= '0;
			fbl_q       <= '0;
			nib_q       <= '0;
			nib_v_q     <= 1'b0;
			copy_left_q <= '0;
			dist_q      <= '0;
			wp_q        <= '0;
			err_q       <= ERR_NONE;
		end else if (accept) begin
			phase_q     <= n_phase;
			hdr_q       <= n_hdr;
			comp_left_q <= n_comp;
			out_left_q  <= n_oleft;
			out_cnt_q   <= n_cnt;
			flag_q      <= n_flag;
			flag_left_q <= n_flag_left;
			asm_q       <= n_asm;
			fbl_q       <= n_fbl;
			nib_q       <= n_nib;
			nib_v_q     <= n_nib_v;
			copy_left_q <= n_copy_left;
			dist_q      <= n_dist;
			wp_q        <= n_wp;
			err_q       <= n_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 16'hFFFF;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

endmodule

// ===== tb/sv/xpress_lz77_frame_decompressor_tb.sv =====
`timescale 1ns / 100ps

module xpress_lz77_frame_decompressor_tb;
	import xlz_pkg::*;

	typedef struct {
		bit        chk;
		in_word_t  w;
		out_word_t e;
	} dir_row_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_word_t    in_word  = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_word;
	logic        cfg_we   = 1'b0;
	logic [15:0] cfg_data = '0;

	// decoder mirror
	bit [15:0]       lim_r;
	phase_t          ph;
	bit [63:0]       hdr_sh;
	int unsigned     comp_left, out_left, blk_cnt;
	bit [31:0]       flags;
	int unsigned     flag_bits;
	bit [31:0]       fasm;
	int unsigned     fbl;
	bit [3:0]        nib_sv;
	bit              nib_ok;
	longint unsigned copy_left;
	int unsigned     mdist;
	bit [7:0]        hist [HistDepth];
	bit [12:0]       wptr;
	err_t            serr;
	bit              r_valid, r_last;
	bit [7:0]        r_byte;

	out_word_t want_q [$];
	bit [7:0]  byte_q [$];
	dir_row_t  dir_tab [$];
	int        fails = 0;
	int        words = 0;
	bit        calm = 0;
	bit        hold_req = 0;
	int        stall_left = 0;

	xpress_lz77_frame_decompressor u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("xpress_lz77_frame_decompressor verification failed");
		$finish;
	end

	function automatic void set_err(err_t c);
		if (serr == ERR_NONE) serr = c;
	endfunction

	function automatic void end_blk();
		fbl = 0;
		ph = (comp_left != 0) ? PH_SKIP : PH_HDR;
	endfunction

	function automatic bit emit(bit [7:0] b);
		hist[wptr] = b;
		wptr++;
		blk_cnt++;
		out_left--;
		r_valid = 1;
		r_byte = b;
		if (out_left == 0) begin
			r_last = 1;
			end_blk();
			return 1;
		end
		return 0;
	endfunction

	function automatic void after_item();
		fbl = 0;
		ph = (flag_bits != 0) ? PH_ITEM : PH_FLAGS;
	endfunction

	function automatic void start_match(longint unsigned len);
		if (mdist > blk_cnt) set_err(ERR_OFFSET);
		else if (len > out_left) set_err(ERR_OVERRUN);
		else begin
			copy_left = len;
			ph = PH_COPY;
		end
	endfunction

	function automatic void resolve_nib(bit [3:0] n);
		if (n < 15) start_match(n + 10);
		else ph = PH_EXT8;
	endfunction

	function automatic void finish_hdr();
		bit [31:0] orig, comp;
		orig = hdr_sh[31:0];
		comp = hdr_sh[63:32];
		fbl = 0;
		if (orig > lim_r || comp > lim_r) set_err(ERR_SIZE);
		else begin
			comp_left = comp;
			out_left = orig;
			blk_cnt = 0;
			nib_ok = 0;
			flag_bits = 0;
			if (orig == 0) ph = (comp != 0) ? PH_SKIP : PH_HDR;
			else if (orig == comp) ph = PH_STORED;
			else ph = PH_FLAGS;
		end
	endfunction

	function automatic void take(bit [7:0] b);
		bit v;
		bit [15:0] t16;
		bit [31:0] v32;
		if (ph == PH_HDR) begin
			hdr_sh = {b, hdr_sh[63:8]};
			if (fbl >= HeaderBytes - 1) finish_hdr();
			else fbl++;
			return;
		end
		comp_left--;
		case (ph)
			PH_STORED: void'(emit(b));
			PH_SKIP: if (comp_left == 0) ph = PH_HDR;
			PH_FLAGS: begin
				fasm = {b, fasm[31:8]};
				fbl++;
				if (fbl == 4) begin
					flags = fasm;
					flag_bits = 32;
					fbl = 0;
					ph = PH_ITEM;
				end
			end
			PH_ITEM: begin
				v = flags[31];
				flags = flags << 1;
				flag_bits--;
				if (!v) begin
					if (!emit(b)) after_item();
				end else begin
					fasm = 32'(b);
					ph = PH_TOKEN;
				end
			end
			PH_TOKEN: begin
				t16 = {b, fasm[7:0]};
				mdist = int'(t16[15:3]) + 1;
				fasm = 0;
				fbl = 0;
				if (t16[2:0] < 7) start_match(t16[2:0] + 3);
				else if (nib_ok) begin
					nib_ok = 0;
					resolve_nib(nib_sv);
				end else ph = PH_NIB;
			end
			PH_NIB: begin
				nib_sv = b[7:4];
				nib_ok = 1;
				resolve_nib(b[3:0]);
			end
			PH_EXT8: begin
				if (b < 255) start_match(b + 25);
				else begin
					fasm = 0;
					fbl = 0;
					ph = PH_EXT16;
				end
			end
			PH_EXT16: begin
				fasm = {b, fasm[31:8]};
				fbl++;
				if (fbl == 2) begin
					v32 = 32'(fasm[31:16]);
					fasm = 0;
					fbl = 0;
					if (v32 == 0) ph = PH_EXT32;
					else if (v32 < 22) set_err(ERR_EXTLEN);
					else start_match(longint'(v32) + 3);
				end
			end
			PH_EXT32: begin
				fasm = {b, fasm[31:8]};
				fbl++;
				if (fbl == 4) begin
					v32 = fasm;
					fbl = 0;
					if (v32 < 22) set_err(ERR_EXTLEN);
					else start_match(longint'(v32) + 3);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic out_word_t decode_word(in_word_t w);
		out_word_t o;
		bit tk;
		bit done;
		bit [12:0] ix;
		tk = 0;
		r_valid = 0;
		r_byte = 0;
		r_last = 0;
		if (serr == ERR_NONE) begin
			if (ph == PH_COPY) begin
				ix = wptr - mdist[12:0];
				copy_left--;
				done = emit(hist[ix]);
				if (!done && copy_left == 0) after_item();
			end else if (ph >= PH_FLAGS && comp_left == 0) begin
				set_err(ERR_SHORT);
			end else if (w.byte_present) begin
				tk = 1;
				take(w.data_byte);
			end
			if (serr == ERR_NONE && w.end_of_stream && ph != PH_COPY &&
					!(ph == PH_HDR && fbl == 0))
				set_err(ERR_TRUNC);
		end
		o.byte_taken = tk;
		o.out_valid = r_valid;
		o.out_byte = r_byte;
		o.block_last = r_last;
		o.error_code = serr;
		return o;
	endfunction

	function automatic void dir_row(bit chk, bit p, bit [7:0] d, bit eos,
			bit tk, bit v, bit [7:0] ob, bit lst);
		dir_row_t r;
		r.chk = chk;
		r.w = '{byte_present: p, data_byte: d, end_of_stream: eos};
		r.e = '{byte_taken: tk, out_valid: v, out_byte: ob, block_last: lst,
			error_code: ERR_NONE};
		dir_tab.insert(dir_tab.size(), r);
	endfunction

	function automatic void hdr_rows(bit [31:0] orig, bit [31:0] comp);
		bit [63:0] h;
		h = {comp, orig};
		for (int k = 0; k < 8; k++) dir_row(1, 1, h[8*k +: 8], 0, 1, 0, 0, 0);
	endfunction

	function automatic void put_hdr(bit [31:0] orig, bit [31:0] comp);
		bit [63:0] h;
		h = {comp, orig};
		for (int k = 0; k < 8; k++) byte_q.insert(byte_q.size(), h[8*k +: 8]);
	endfunction

	function automatic void put_rand(int n);
		repeat (n) byte_q.insert(byte_q.size(), 8'($urandom));
	endfunction

	function automatic void build_lz(int orig, int lmax, int extra);
		bit [7:0] pl [$];
		bit [31:0] fw;
		bit [31:0] xl;
		bit [15:0] t;
		bit npend;
		int prod, fidx, fpos, rem, len, d, low, n, npos, enc, comp;
		prod = 0;
		fidx = 32;
		npend = 0;
		fw = 0;
		fpos = 0;
		npos = 0;
		while (prod < orig) begin
			if (fidx == 32) begin
				fpos = pl.size();
				repeat (4) pl.insert(pl.size(), 8'h00);
				fw = 0;
				fidx = 0;
			end
			rem = orig - prod;
			if (prod > 0 && rem >= 3 && $urandom_range(0, 2) != 0) begin
				fw[31 - fidx] = 1'b1;
				d = $urandom_range(1, prod < HistDepth ? prod : HistDepth);
				len = $urandom_range(3, rem < lmax ? rem : lmax);
				low = len < 10 ? len - 3 : 7;
				t = 16'(((d - 1) << 3) | low);
				pl.insert(pl.size(), t[7:0]);
				pl.insert(pl.size(), t[15:8]);
				if (len >= 10) begin
					n = len < 25 ? len - 10 : 15;
					if (npend) begin
						pl[npos] = pl[npos] | 8'(n << 4);
						npend = 0;
					end else begin
						npos = pl.size();
						pl.insert(pl.size(), 8'(n));
						npend = 1;
					end
				end
				if (len >= 25) begin
					enc = $urandom_range(len <= 279 ? 0 : 1, 2);
					xl = len - 3;
					if (enc == 0) pl.insert(pl.size(), 8'(len - 25));
					else begin
						pl.insert(pl.size(), 8'hff);
						if (enc == 1) begin
							pl.insert(pl.size(), xl[7:0]);
							pl.insert(pl.size(), xl[15:8]);
						end else begin
							pl.insert(pl.size(), 8'h00);
							pl.insert(pl.size(), 8'h00);
							for (int k = 0; k < 4; k++) pl.insert(pl.size(), xl[8*k +: 8]);
						end
					end
				end
				prod += len;
			end else begin
				pl.insert(pl.size(), 8'($urandom));
				prod++;
			end
			fidx++;
			if (fidx == 32 || prod >= orig)
				for (int k = 0; k < 4; k++) pl[fpos + k] = fw[8*k +: 8];
		end
		comp = pl.size() + extra;
		if (comp == orig) comp++;
		if (comp > lim_r) begin
			put_hdr(orig, orig);
			put_rand(orig);
		end else begin
			put_hdr(orig, comp);
			foreach (pl[k]) byte_q.insert(byte_q.size(), pl[k]);
			put_rand(comp - pl.size());
		end
	endfunction

	function automatic void add_frame();
		int r, c, cap;
		cap = lim_r < 150 ? lim_r : 150;
		r = $urandom_range(0, 9);
		if (lim_r == 0) put_hdr(0, 0);
		else if (r == 0) begin
			c = $urandom_range(0, lim_r < 5 ? lim_r : 5);
			put_hdr(0, c);
			put_rand(c);
		end else if (r < 3) begin
			c = $urandom_range(1, lim_r < 40 ? lim_r : 40);
			put_hdr(c, c);
			put_rand(c);
		end else build_lz($urandom_range(1, cap), 30, $urandom_range(0, 3));
	endfunction

	task automatic send_word(in_word_t w, bit fixed, out_word_t fe, output bit tk);
		int g;
		out_word_t p;
		g = calm ? 0 : $urandom_range(0, 19);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		p = decode_word(w);
		tk = p.byte_taken;
		want_q.insert(want_q.size(), fixed ? fe : p);
		words++;
	endtask

	task automatic pump();
		in_word_t w;
		out_word_t none;
		bit tk;
		none = '0;
		while ((byte_q.size() > 0 || ph == PH_COPY) && serr == ERR_NONE) begin
			w.end_of_stream = 0;
			if (byte_q.size() == 0 || $urandom_range(0, 7) == 0) begin
				w.byte_present = 0;
				w.data_byte = 8'($urandom);
				if ((ph == PH_HDR && fbl == 0) ||
						(ph == PH_COPY && copy_left > 1 && out_left > 1))
					w.end_of_stream = 1'($urandom);
			end else begin
				w.byte_present = 1;
				w.data_byte = byte_q[0];
			end
			send_word(w, 0, none, tk);
			if (tk) void'(byte_q.pop_front());
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(bit [15:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_r = v;
	endtask

	task automatic run_frames(int n);
		int target;
		target = words + n;
		while (words < target) begin
			calm = ($urandom_range(0, 3) == 0);
			add_frame();
			pump();
		end
		calm = 0;
	endtask

	task automatic report(string f, int e, int a);
		$display("%0t ns: %s expected %0h got %0h", $time, f, e, a);
		fails++;
	endtask

	initial begin
		out_word_t e;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0) out_stall <= 1'b0;
			end else if (out_valid && !out_stall) begin
				if (want_q.size() == 0) begin
					$display("%0t ns: unexpected word %0h", $time, out_word);
					fails++;
				end else begin
					e = want_q.pop_front();
					if (out_word.byte_taken !== e.byte_taken)
						report("byte_taken", e.byte_taken, out_word.byte_taken);
					if (out_word.out_valid !== e.out_valid)
						report("out_valid", e.out_valid, out_word.out_valid);
					if (out_word.out_byte !== e.out_byte)
						report("out_byte", e.out_byte, out_word.out_byte);
					if (out_word.block_last !== e.block_last)
						report("block_last", e.block_last, out_word.block_last);
					if (out_word.error_code !== e.error_code)
						report("error_code", e.error_code, out_word.error_code);
				end
				stall_left = hold_req ? 400 : (calm ? 0 : $urandom_range(0, 19));
				hold_req = 0;
				if (stall_left > 0) out_stall <= 1'b1;
			end
		end
	end

	initial begin
		in_word_t w;
		out_word_t none;
		bit tk;
		int kind;
		none = '0;
		lim_r = 16'hffff;
		ph = PH_HDR;
		hdr_sh = 0;
		comp_left = 0;
		out_left = 0;
		blk_cnt = 0;
		flags = 0;
		flag_bits = 0;
		fasm = 0;
		fbl = 0;
		nib_sv = 0;
		nib_ok = 0;
		copy_left = 0;
		mdist = 0;
		wptr = 0;
		serr = ERR_NONE;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stored frame, then literal plus overlapping match, then eos between frames
		hdr_rows(1, 1);
		dir_row(1, 1, 8'ha5, 0, 1, 1, 8'ha5, 1);
		hdr_rows(4, 7);
		dir_row(1, 1, 8'h00, 0, 1, 0, 0, 0);
		dir_row(1, 1, 8'h00, 0, 1, 0, 0, 0);
		dir_row(1, 1, 8'h00, 0, 1, 0, 0, 0);
		dir_row(1, 1, 8'h40, 0, 1, 0, 0, 0);
		dir_row(1, 1, 8'hff, 0, 1, 1, 8'hff, 0);
		dir_row(1, 1, 8'h00, 0, 1, 0, 0, 0);
		dir_row(1, 1, 8'h00, 0, 1, 0, 0, 0);
		repeat (3) dir_row(0, 1, 8'h5a, 0, 0, 0, 0, 0);
		dir_row(1, 0, 8'h00, 1, 0, 0, 0, 0);
		foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].chk, dir_tab[i].e, tk);
		wait_idle();

		cfg_write(16'd0);
		repeat (3) put_hdr(0, 0);
		pump();
		wait_idle();

		cfg_write(16'($urandom_range(300, 2000)));
		run_frames(350);
		wait_idle();

		// long block with extended-length matches; receiver holds off to back up the input
		cfg_write(16'hffff);
		calm = 1;
		hold_req = 1;
		build_lz(300, 300, 2);
		pump();
		calm = 0;
		run_frames(350);
		wait_idle();

		cfg_write(16'($urandom_range(1, 65534)));
		run_frames(350);
		wait_idle();

		kind = $urandom_range(1, 6);
		case (kind)
			1: put_hdr(32'(lim_r) + 1, 0);
			2: begin
				put_hdr(10, 20);
				byte_q = {byte_q, 8'h00, 8'h00, 8'h00, 8'h80, 8'h08, 8'h00};
			end
			3: begin
				put_hdr(100, 50);
				byte_q = {byte_q, 8'h00, 8'h00, 8'h00, 8'h80, 8'h07, 8'h00,
					8'h0f, 8'hff, 8'h05, 8'h00};
			end
			4: begin
				put_hdr(5, 30);
				byte_q = {byte_q, 8'h00, 8'h00, 8'h00, 8'h40, 8'haa, 8'h06, 8'h00};
			end
			5: begin
				put_hdr(10, 3);
				put_rand(3);
			end
			default: put_rand(4);
		endcase
		if (lim_r < 100) cfg_write(16'hffff);
		if (kind == 1) begin
			byte_q.delete();
			put_hdr(32'(lim_r) + 1, 0);
		end
		pump();
		byte_q.delete();
		repeat (12) begin
			w.byte_present = 1'($urandom);
			w.data_byte = 8'($urandom);
			w.end_of_stream = 1;
			send_word(w, 0, none, tk);
		end
		wait_idle();

		if (fails == 0 && want_q.size() == 0)
			$display("xpress_lz77_frame_decompressor verification clean");
		else
			$display("xpress_lz77_frame_decompressor verification failed");
		$finish;
	end

endmodule

// ===== xpress_lz77_frame_decompressor.f =====
hw/rtl/xlz_pkg.sv
hw/rtl/xlz_hist.sv
hw/rtl/xlz_ctrl.sv
hw/rtl/xpress_lz77_frame_decompressor.sv
tb/sv/xpress_lz77_frame_decompressor_tb.sv
